// ===== hdl/epf_pkg.sv =====
package epf_pkg;

  // Wire escape codes and configuration defaults
  localparam logic [7:0] EscLead       = 8'hD0;
  localparam logic [7:0] EscCharE0     = 8'hE0;
  localparam logic [7:0] EscCodeD0     = 8'hCF;
  localparam logic [7:0] EscCodeE0     = 8'hDF;
  localparam logic [7:0] SyncDef       = 8'hE0;
  localparam logic [7:0] MaxPayloadDef = 8'hFE;

  // Token slots per job; a start fills sync, address, count, checksum
  localparam int unsigned NumTok  = 4;
  localparam int unsigned TokIdxW = $clog2(NumTok);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_NO_FRAME  = 2'd2
  } status_e;

  typedef enum logic {
    CFG_SYNC        = 1'b0,
    CFG_MAX_PAYLOAD = 1'b1
  } cfg_idx_e;

  // One classified input word: raw tokens for the back end to escape and send
  typedef struct packed {
    logic [TokIdxW-1:0]         last_tok;
    logic [NumTok-1:0][7:0]     tok;
    logic [NumTok-1:0]          esc_en;
    logic                       ends_frame;
    status_e                    status;
  } job_t;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == EscLead) || (b == EscCharE0);
  endfunction

  function automatic logic [7:0] esc_code(input logic [7:0] b);
    return (b == EscLead) ? EscCodeD0 : EscCodeE0;
  endfunction

endpackage

// ===== hdl/epf_in_if.sv =====
interface epf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] node_address;
  logic [7:0] payload_length;
  logic [7:0] data_byte;

  modport source (output valid, command, node_address, payload_length, data_byte,
                  input ready);
  modport sink (input valid, command, node_address, payload_length, data_byte,
                output ready);
endinterface

// ===== hdl/epf_out_if.sv =====
interface epf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_done;
  logic [1:0] status;

  modport source (output valid, out_byte, run_last, frame_done, status,
                  input ready);
  modport sink (input valid, out_byte, run_last, frame_done, status,
                output ready);
endinterface

// ===== hdl/epf_front.sv =====
module epf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  epf_in_if.sink            in_i,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              q_full_i,
  output logic              push_o,
  output epf_pkg::job_t     job_o
);

  logic [7:0] sync_q, max_q;
  logic       open_q, open_d;
  logic [7:0] left_q, left_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] count, start_sum, data_sum, left_dec;
  logic       accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= epf_pkg::SyncDef;
      max_q  <= epf_pkg::MaxPayloadDef;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == epf_pkg::CFG_SYNC) begin
        sync_q <= cfg_wdata_i;
      end else begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  // Classify the word and compute the next frame state
  always_comb begin
    count     = in_i.payload_length + 8'd1;
    start_sum = in_i.node_address + count;
    data_sum  = sum_q + in_i.data_byte;
    left_dec  = left_q - 8'd1;
    job_o     = '0;
    job_o.status = epf_pkg::STAT_OK;
    open_d    = open_q;
    left_d    = left_q;
    sum_d     = sum_q;
    if (in_i.command == epf_pkg::CMD_START) begin
      if (in_i.payload_length > max_q) begin
        job_o.status = epf_pkg::STAT_TOO_LARGE;
        open_d       = 1'b0;
        left_d       = '0;
      end else begin
        job_o.tok[0] = sync_q;
        job_o.tok[1] = in_i.node_address;
        job_o.tok[2] = count;
        job_o.tok[3] = start_sum;
        job_o.esc_en = 4'b1110;
        left_d       = in_i.payload_length;
        sum_d        = start_sum;
        if (in_i.payload_length == '0) begin
          job_o.last_tok   = epf_pkg::TokIdxW'(3);
          job_o.ends_frame = 1'b1;
          open_d           = 1'b0;
        end else begin
          job_o.last_tok = epf_pkg::TokIdxW'(2);
          open_d         = 1'b1;
        end
      end
    end else if (!open_q) begin
      job_o.status = epf_pkg::STAT_NO_FRAME;
    end else begin
      job_o.tok[0] = in_i.data_byte;
      job_o.tok[1] = data_sum;
      job_o.esc_en = 4'b0011;
      sum_d        = data_sum;
      left_d       = left_dec;
      if (left_dec == '0) begin
        job_o.last_tok   = epf_pkg::TokIdxW'(1);
        job_o.ends_frame = 1'b1;
        open_d           = 1'b0;
      end
    end
  end

  // Advance frame state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= '0;
      sum_q  <= '0;
    end else if (accept) begin
      open_q <= open_d;
      left_q <= left_d;
      sum_q  <= sum_d;
    end
  end

endmodule

// ===== hdl/epf_queue.sv =====
module epf_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  epf_pkg::job_t     job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output epf_pkg::job_t     job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  epf_pkg::job_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  // Store jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hdl/epf_back.sv =====
module epf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  epf_pkg::job_t     job_i,
  output logic              pop_o,
  epf_out_if.source         out_o
);

  logic [epf_pkg::TokIdxW-1:0] idx_q;
  logic                        half_q;
  logic                        out_valid_q;
  logic [7:0]                  byte_q;
  logic                        run_last_q, frame_done_q;
  logic [1:0]                  status_q;
  logic [7:0]                  cur, wire_byte;
  logic                        esc, tok_end, job_end, fire;

  // Pick the wire word for the current token
  always_comb begin
    cur       = job_i.tok[idx_q];
    esc       = job_i.esc_en[idx_q] && epf_pkg::needs_esc(cur);
    tok_end   = !esc || half_q;
    job_end   = tok_end && (idx_q == job_i.last_tok);
    fire      = job_valid_i && (!out_valid_q || out_o.ready);
    wire_byte = half_q ? epf_pkg::esc_code(cur) : (esc ? epf_pkg::EscLead : cur);
  end

  assign pop_o = fire && job_end;

  // Walk tokens and escape halves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        if (tok_end) begin
          half_q <= 1'b0;
          idx_q  <= job_end ? '0 : idx_q + epf_pkg::TokIdxW'(1);
        end else begin
          half_q <= 1'b1;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold output word until taken
  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q       <= wire_byte;
      run_last_q   <= job_end;
      frame_done_q <= job_end && job_i.ends_frame;
      status_q     <= job_i.status;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.run_last   = run_last_q;
  assign out_o.frame_done = frame_done_q;
  assign out_o.status     = status_q;

endmodule

// ===== hdl/escaped_packet_framer.sv =====
// Channel   Role    Payload
// in_i      sink    command, node_address, payload_length, data_byte
// out_o     source  out_byte, run_last, frame_done, status
// cfg       write   cfg_we_i, cfg_idx_i (0 sync_byte, 1 max_payload), cfg_wdata_i
//
// The back end sends one wire word per cycle while out_o is ready: a start sends
// sync, address, count; a data word its byte; frame end the checksum; errors 00.
// The front end classifies a word in the cycle it is accepted and queues it;
// input and output stall independently through a QDepth-entry job queue.
// Reset is asynchronous and clears all but the data registers at once; no sweep.
module escaped_packet_framer #(
  parameter int unsigned QDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  epf_in_if.sink     in_i,
  epf_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  epf_pkg::job_t push_job, head_job;
  logic          push, q_full, q_valid, pop;

  epf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  epf_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  epf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

// ===== hdl/epf_checker.sv =====
module epf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       frame_done,
  input logic [1:0] status
);

  // Hold a stalled word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(run_last)
                                && $stable(frame_done) && $stable(status))
    else $error("output payload changed while stalled");

  // Frame end is always the last word of its input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && frame_done |-> run_last)
    else $error("frame_done without run_last");

  // Error words stand alone with a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status != epf_pkg::STAT_OK) |-> run_last && !frame_done
                                                  && (out_byte == 8'h00))
    else $error("malformed error word");

endmodule

bind escaped_packet_framer epf_checker u_epf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_byte   (out_o.out_byte),
  .run_last   (out_o.run_last),
  .frame_done (out_o.frame_done),
  .status     (out_o.status)
);
